FILE: rtl/sttt_pkg.sv
// Shared types and constants of the search transposition table.
`timescale 1ns / 1ps

package sttt_pkg;

    // Default number of index bits; the table holds two to this power entries.
    localparam int INDEX_BITS_DEF = 16;

    // Operation codes; the fourth code has no meaning and is answered with zeros.
    localparam logic [1:0] OP_PROBE = 2'd0;
    localparam logic [1:0] OP_STORE = 2'd1;
    localparam logic [1:0] OP_QUERY = 2'd2;

    // Bound kinds kept with a score.
    localparam logic [1:0] BOUND_NONE  = 2'd0;
    localparam logic [1:0] BOUND_EXACT = 2'd1;
    localparam logic [1:0] BOUND_LOWER = 2'd2;
    localparam logic [1:0] BOUND_UPPER = 2'd3;

    // One request as it arrives on the input channel.
    typedef struct packed {
        logic        [1:0]  opcode;
        logic        [63:0] position_key;
        logic signed [7:0]  search_depth;
        logic signed [15:0] window_alpha;
        logic signed [15:0] window_beta;
        logic signed [15:0] new_score;
        logic        [1:0]  new_bound;
        logic        [15:0] new_move;
    } t_req;

    // One response as it leaves on the output channel.
    typedef struct packed {
        logic               found;
        logic signed [15:0] score_out;
        logic               move_valid;
        logic        [15:0] move_out;
    } t_resp;

    // One table entry: the full key and the payload beside it.
    typedef struct packed {
        logic        [63:0] key;
        logic        [15:0] move;
        logic        [1:0]  bound;
        logic signed [15:0] score;
        logic signed [7:0]  depth;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    // What the evaluation hands back: the response and the write-back order.
    typedef struct packed {
        t_resp  resp;
        logic   wr_en;
        t_entry wr_entry;
    } t_eval;

endpackage

FILE: rtl/search_transposition_table.sv
// Top level of the direct-mapped, depth-preferred search transposition table.
//
// Requests enter on the input channel (i_in_valid, o_in_stall, i_in_data) and
// each gives exactly one response on the output channel (o_out_valid,
// i_out_stall, o_out_data), in request order. Probes, stores and best-move
// queries all answer; a store answers with all fields zero.
// A request is accepted at an edge with valid high and stall low. The entry
// memory is read at that edge; when the waiting request advances, the entry
// is evaluated, the write-back is made and the response is loaded into the
// output register, which drives o_out_valid and o_out_data.
// One request per cycle is sustained while the receiver does not stall: the
// single read and single write port of the entry memory set this figure. A
// store followed at once by an access to the same slot takes the written
// entry from a forwarding register.
// After reset the memory is cleared one entry a cycle, through all 2**INDEX_BITS
// entries, during which o_in_stall is high.
// When the receiver stalls, the response waits in the output register, one
// further request may be accepted and held, and then o_in_stall rises.
`timescale 1ns / 1ps

module search_transposition_table #(
    parameter int INDEX_BITS = sttt_pkg::INDEX_BITS_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_stall,
    input  sttt_pkg::t_req  i_in_data,
    output logic            o_out_valid,
    input  logic            i_out_stall,
    output sttt_pkg::t_resp o_out_data
);
    import sttt_pkg::*;

    // Clearing pass state.
    logic                  r_clr_busy;
    logic [INDEX_BITS-1:0] r_clr_idx;

    // Request waiting for its entry.
    logic                  r_p_valid;
    t_req                  r_p_req;

    // Forwarding of a write to the slot read at the same edge.
    logic                  r_fwd;
    t_entry                r_fwd_entry;

    // Output register.
    logic                  r_o_valid;
    t_resp                 r_o_data;

    logic                  in_acc;
    logic                  advance;
    logic [INDEX_BITS-1:0] in_idx;
    logic [INDEX_BITS-1:0] p_idx;
    t_entry                rd_entry;
    t_entry                cur_entry;
    t_eval                 ev;
    logic                  wr_en;
    logic [INDEX_BITS-1:0] wr_addr;
    t_entry                wr_data;
    logic                  n_fwd;

    // Handshake and pipeline advance.
    assign advance    = r_p_valid && (!r_o_valid || !i_out_stall);
    assign o_in_stall = r_clr_busy || (r_p_valid && !advance);
    assign in_acc     = i_in_valid && !o_in_stall;
    assign in_idx     = i_in_data.position_key[INDEX_BITS-1:0];
    assign p_idx      = r_p_req.position_key[INDEX_BITS-1:0];

    // The freshest copy of the slot for the waiting request.
    assign cur_entry = r_fwd ? r_fwd_entry : rd_entry;

    sttt_eval u_eval (
        .i_req   (r_p_req),
        .i_entry (cur_entry),
        .o_eval  (ev)
    );

    // Write port: the clearing pass, or the write-back of a store.
    always_comb begin
        if (r_clr_busy) begin
            wr_en   = 1'b1;
            wr_addr = r_clr_idx;
            wr_data = '0;
        end else begin
            wr_en   = advance && ev.wr_en;
            wr_addr = p_idx;
            wr_data = ev.wr_entry;
        end
    end

    assign n_fwd = in_acc && advance && ev.wr_en && (p_idx == in_idx);

    sttt_mem #(
        .INDEX_BITS (INDEX_BITS)
    ) u_mem (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (in_acc),
        .i_rd_addr (in_idx),
        .o_rd_data (rd_entry)
    );

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_idx  <= '0;
            r_p_valid  <= 1'b0;
            r_fwd      <= 1'b0;
            r_o_valid  <= 1'b0;
        end else begin
            if (r_clr_busy) begin
                r_clr_idx <= r_clr_idx + 1'b1;
                if (r_clr_idx == '1) begin
                    r_clr_busy <= 1'b0;
                end
            end
            if (in_acc) begin
                r_p_valid <= 1'b1;
                r_fwd     <= n_fwd;
            end else if (advance) begin
                r_p_valid <= 1'b0;
            end
            if (advance) begin
                r_o_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_p_req     <= i_in_data;
            r_fwd_entry <= ev.wr_entry;
        end
        if (advance) begin
            r_o_data <= ev.resp;
        end
    end

    assign o_out_valid = r_o_valid;
    assign o_out_data  = r_o_data;

    // A store always answers with an all-zero response.
    a_store_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && (r_p_req.opcode == OP_STORE)) |=> (r_o_data == '0))
        else $error("store response is not all zero");

    // Forwarding is only switched on after a write in the previous cycle.
    a_fwd_after_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_fwd) |-> $past(wr_en))
        else $error("forwarding without a preceding write");

    // A usable score is only reported together with a key match.
    a_found_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_valid && (r_o_data.score_out != 16'd0)) |-> r_o_data.move_valid)
        else $error("score reported without a key match");

    // No request is pending while the memory is being cleared.
    a_clear_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clr_busy |-> !r_p_valid)
        else $error("request pending during clearing pass");

endmodule

FILE: rtl/sttt_mem.sv
// Entry memory: one write port, one read port with registered read data.
`timescale 1ns / 1ps

module sttt_mem #(
    parameter int INDEX_BITS = sttt_pkg::INDEX_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_wr_en,
    input  logic [INDEX_BITS-1:0] i_wr_addr,
    input  sttt_pkg::t_entry      i_wr_data,
    input  logic                  i_rd_en,
    input  logic [INDEX_BITS-1:0] i_rd_addr,
    output sttt_pkg::t_entry      o_rd_data
);
    import sttt_pkg::*;

    localparam int DEPTH = 1 << INDEX_BITS;

    logic [ENTRY_W-1:0] mem [DEPTH];
    logic [ENTRY_W-1:0] r_rd_data;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Read port; a read and a write to one address in one cycle return the old data.
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= mem[i_rd_addr];
        end
    end

    assign o_rd_data = t_entry'(r_rd_data);

endmodule

FILE: rtl/sttt_eval.sv
// Evaluation of one request against the entry read for it.
`timescale 1ns / 1ps

module sttt_eval (
    input  sttt_pkg::t_req   i_req,
    input  sttt_pkg::t_entry i_entry,
    output sttt_pkg::t_eval  o_eval
);
    import sttt_pkg::*;

    logic match;
    logic deep_enough;
    logic score_usable;
    logic replace;

    // Key match and the tests on the stored score.
    assign match       = (i_entry.key == i_req.position_key);
    assign deep_enough = (i_entry.depth >= i_req.search_depth);
    assign score_usable = (i_entry.bound == BOUND_EXACT) ||
                          ((i_entry.bound == BOUND_LOWER) &&
                           (i_entry.score >= i_req.window_beta)) ||
                          ((i_entry.bound == BOUND_UPPER) &&
                           (i_entry.score <= i_req.window_alpha));

    // Depth-preferred replacement: empty slot, same position, or at least as deep.
    assign replace = (i_entry.key == 64'd0) || match ||
                     (i_req.search_depth >= i_entry.depth);

    always_comb begin
        o_eval                   = '0;
        o_eval.wr_entry.key      = i_req.position_key;
        o_eval.wr_entry.depth    = i_req.search_depth;
        o_eval.wr_entry.score    = i_req.new_score;
        o_eval.wr_entry.bound    = i_req.new_bound;
        // A null move keeps the move already in the slot.
        o_eval.wr_entry.move     = (i_req.new_move != 16'd0) ? i_req.new_move
                                                             : i_entry.move;
        unique case (i_req.opcode)
            OP_PROBE: begin
                if (match) begin
                    o_eval.resp.move_valid = 1'b1;
                    o_eval.resp.move_out   = i_entry.move;
                    if (deep_enough && score_usable) begin
                        o_eval.resp.found     = 1'b1;
                        o_eval.resp.score_out = i_entry.score;
                    end
                end
            end
            OP_STORE: begin
                o_eval.wr_en = replace;
            end
            OP_QUERY: begin
                if (match) begin
                    o_eval.resp.move_valid = 1'b1;
                    o_eval.resp.move_out   = i_entry.move;
                    o_eval.resp.found      = (i_entry.move != 16'd0);
                end
            end
            default: begin
                o_eval.wr_en = 1'b0;
            end
        endcase
    end

endmodule
